// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hue and saturation core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rstn is high.
`define RHS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define RHS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/rhs_pkg.sv -----
// ----------------------------------------------------------------------------
// Hue and saturation package
// Types and constants shared by the hue and saturation pipeline.
// ----------------------------------------------------------------------------
package rhs_pkg;

    typedef enum logic [2:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE,
        TIE_RED_GREEN,
        TIE_GREEN_BLUE,
        TIE_RED_BLUE,
        SECT_GRAY
    } sector_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    localparam int unsigned RECIP_SHIFT = 16;
    localparam int unsigned NUM_W       = 16;
    localparam int unsigned DEN_W       = 8;

    localparam logic [7:0]         HUE_SCALE   = 8'd60;
    localparam logic [7:0]         SAT_FULL    = 8'd255;
    localparam logic signed [10:0] HUE_GRAY    = -11'sd60;
    localparam logic signed [10:0] HUE_RG      = 11'sd60;
    localparam logic signed [10:0] HUE_GB      = 11'sd180;
    localparam logic signed [10:0] HUE_RB      = 11'sd300;
    localparam logic signed [16:0] GREEN_BASE  = 17'sd120;
    localparam logic signed [16:0] BLUE_BASE   = 17'sd240;
    localparam logic signed [10:0] HUE_WRAP    = 11'sd360;
    localparam logic signed [10:0] SKIN_LIMIT  = 11'sd180;

endpackage

// ----- design/rhs_recip_div.sv -----
// ----------------------------------------------------------------------------
// Reciprocal divider
// Three-stage unsigned divider: reciprocal lookup, multiply, and a single
// remainder correction step. The quotient is exact for any nonzero divisor.
// ----------------------------------------------------------------------------
module rhs_recip_div (
    input  logic                           aclk,
    input  rhs_pkg::stage_en_t             en,
    input  logic [rhs_pkg::NUM_W-1:0]      num_in,
    input  logic [rhs_pkg::DEN_W-1:0]      den_in,
    output logic [rhs_pkg::NUM_W-1:0]      quo_out
);

    localparam int unsigned RECIP_W = rhs_pkg::RECIP_SHIFT + 1;
    localparam int unsigned TAB_N   = 1 << rhs_pkg::DEN_W;

    logic [RECIP_W-1:0] recip_tab [TAB_N];

    for (genvar gi = 0; gi < TAB_N; gi++) begin : g_recip
        localparam int unsigned VAL =
            (gi == 0) ? 0 : (1 << rhs_pkg::RECIP_SHIFT) / ((gi == 0) ? 1 : gi);
        assign recip_tab[gi] = RECIP_W'(VAL);
    end

    logic [rhs_pkg::NUM_W-1:0]         num_a_reg, num_b_reg;
    logic [rhs_pkg::DEN_W-1:0]         den_a_reg, den_b_reg;
    logic [RECIP_W-1:0]                recip_a_reg;
    logic [rhs_pkg::NUM_W-1:0]         q0_b_reg;
    logic [rhs_pkg::NUM_W-1:0]         quo_reg;

    logic [rhs_pkg::NUM_W+RECIP_W-1:0] prod;
    logic [rhs_pkg::NUM_W-1:0]         q0_next;
    logic [rhs_pkg::NUM_W+rhs_pkg::DEN_W-1:0] back;
    logic [rhs_pkg::NUM_W+rhs_pkg::DEN_W-1:0] rem;
    logic [rhs_pkg::NUM_W-1:0]         quo_next;

    always_comb begin
        prod     = (rhs_pkg::NUM_W+RECIP_W)'(num_a_reg) * (rhs_pkg::NUM_W+RECIP_W)'(recip_a_reg);
        q0_next  = prod[rhs_pkg::RECIP_SHIFT +: rhs_pkg::NUM_W];
        back     = (rhs_pkg::NUM_W+rhs_pkg::DEN_W)'(q0_b_reg)
                 * (rhs_pkg::NUM_W+rhs_pkg::DEN_W)'(den_b_reg);
        rem      = (rhs_pkg::NUM_W+rhs_pkg::DEN_W)'(num_b_reg) - back;
        quo_next = (rem >= (rhs_pkg::NUM_W+rhs_pkg::DEN_W)'(den_b_reg))
                 ? q0_b_reg + 1'b1 : q0_b_reg;
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            num_a_reg   <= num_in;
            den_a_reg   <= den_in;
            recip_a_reg <= recip_tab[den_in];
        end
        if (en.s2) begin
            num_b_reg <= num_a_reg;
            den_b_reg <= den_a_reg;
            q0_b_reg  <= q0_next;
        end
        if (en.s3) begin
            quo_reg <= quo_next;
        end
    end

    assign quo_out = quo_reg;

endmodule

// ----- design/rgb_to_hue_saturation_core.sv -----
// ----------------------------------------------------------------------------
// RGB to hue and saturation core
// Each pixel passes the input register, the divider stages and the output register.
// Throughput is one pixel per cycle while m_tready is high; occupied stages hold under backpressure.
// The three-stage reciprocal dividers set the pipeline depth.
// Reset (aresetn low, synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_to_hue_saturation_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // hue_deg[8:0], skin_hue_deg[17:9],
                                   // saturation[25:18], zero[31:26]
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    assign en5      = !v5_reg || m_tready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    logic [7:0]          red, green, blue, mx_next, mn_next, delta_next;
    rhs_pkg::sector_t    sector_next;
    logic [15:0]         num_r_next, num_g_next, num_b_next, num_s_next;

    always_comb begin
        red   = s_tdata[7:0];
        green = s_tdata[15:8];
        blue  = s_tdata[23:16];
        mx_next = red;
        if (green > mx_next) mx_next = green;
        if (blue > mx_next)  mx_next = blue;
        mn_next = red;
        if (green < mn_next) mn_next = green;
        if (blue < mn_next)  mn_next = blue;
        delta_next = mx_next - mn_next;
        if (delta_next == 8'd0) begin
            sector_next = rhs_pkg::SECT_GRAY;
        end else if (red > green && red > blue) begin
            sector_next = rhs_pkg::SECT_RED;
        end else if (green > red && green > blue) begin
            sector_next = rhs_pkg::SECT_GREEN;
        end else if (blue > red && blue > green) begin
            sector_next = rhs_pkg::SECT_BLUE;
        end else if (red == green && red == mx_next) begin
            sector_next = rhs_pkg::TIE_RED_GREEN;
        end else if (green == blue && green == mx_next) begin
            sector_next = rhs_pkg::TIE_GREEN_BLUE;
        end else begin
            sector_next = rhs_pkg::TIE_RED_BLUE;
        end
        num_r_next = 16'(red)   * 16'(rhs_pkg::HUE_SCALE);
        num_g_next = 16'(green) * 16'(rhs_pkg::HUE_SCALE);
        num_b_next = 16'(blue)  * 16'(rhs_pkg::HUE_SCALE);
        num_s_next = 16'(delta_next) * 16'(rhs_pkg::SAT_FULL);
    end

    logic [15:0]      num_r_reg, num_g_reg, num_b_reg, num_s_reg;
    logic [7:0]       delta_reg, mx_reg;
    rhs_pkg::sector_t sect1_reg, sect2_reg, sect3_reg, sect4_reg;
    logic             blk1_reg, blk2_reg, blk3_reg, blk4_reg;

    always_ff @(posedge aclk) begin
        if (en1) begin
            num_r_reg <= num_r_next;
            num_g_reg <= num_g_next;
            num_b_reg <= num_b_next;
            num_s_reg <= num_s_next;
            delta_reg <= delta_next;
            mx_reg    <= mx_next;
            sect1_reg <= sector_next;
            blk1_reg  <= (mx_next == 8'd0);
        end
        if (en2) begin
            sect2_reg <= sect1_reg;
            blk2_reg  <= blk1_reg;
        end
        if (en3) begin
            sect3_reg <= sect2_reg;
            blk3_reg  <= blk2_reg;
        end
        if (en4) begin
            sect4_reg <= sect3_reg;
            blk4_reg  <= blk3_reg;
        end
    end

    rhs_pkg::stage_en_t div_en;
    logic [15:0]        rs, gs, bs, sq;

    assign div_en = '{s1: en2, s2: en3, s3: en4};

    rhs_recip_div u_div_r (.aclk(aclk), .en(div_en), .num_in(num_r_reg),
                           .den_in(delta_reg), .quo_out(rs));
    rhs_recip_div u_div_g (.aclk(aclk), .en(div_en), .num_in(num_g_reg),
                           .den_in(delta_reg), .quo_out(gs));
    rhs_recip_div u_div_b (.aclk(aclk), .en(div_en), .num_in(num_b_reg),
                           .den_in(delta_reg), .quo_out(bs));
    rhs_recip_div u_div_s (.aclk(aclk), .en(div_en), .num_in(num_s_reg),
                           .den_in(mx_reg), .quo_out(sq));

    logic signed [16:0] rs_s, gs_s, bs_s, h_wide;
    logic signed [10:0] h_raw, hue_w, skin_w;
    logic [8:0]         hue_next, skin_next;
    logic [7:0]         sat_next;

    always_comb begin
        rs_s = $signed({1'b0, rs});
        gs_s = $signed({1'b0, gs});
        bs_s = $signed({1'b0, bs});
        case (sect4_reg)
            rhs_pkg::SECT_RED:       h_wide = gs_s - bs_s;
            rhs_pkg::SECT_GREEN:     h_wide = rhs_pkg::GREEN_BASE + bs_s - rs_s;
            rhs_pkg::SECT_BLUE:      h_wide = rhs_pkg::BLUE_BASE + rs_s - gs_s;
            rhs_pkg::TIE_RED_GREEN:  h_wide = 17'(rhs_pkg::HUE_RG);
            rhs_pkg::TIE_GREEN_BLUE: h_wide = 17'(rhs_pkg::HUE_GB);
            rhs_pkg::TIE_RED_BLUE:   h_wide = 17'(rhs_pkg::HUE_RB);
            default:                 h_wide = 17'(rhs_pkg::HUE_GRAY);
        endcase
        h_raw     = h_wide[10:0];
        hue_w     = (h_raw < 0) ? h_raw + rhs_pkg::HUE_WRAP : h_raw;
        skin_w    = (h_raw > rhs_pkg::SKIN_LIMIT) ? h_raw - rhs_pkg::HUE_WRAP : h_raw;
        hue_next  = hue_w[8:0];
        skin_next = skin_w[8:0];
        sat_next  = blk4_reg ? rhs_pkg::SAT_FULL : sq[7:0];
    end

    logic [8:0] hue_reg, skin_reg;
    logic [7:0] sat_reg;

    always_ff @(posedge aclk) begin
        if (en5) begin
            hue_reg  <= hue_next;
            skin_reg <= skin_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = {6'd0, sat_reg, skin_reg, hue_reg};

    `RHS_ASSERT(a_ready_when_empty, aclk, aresetn, !v5_reg |-> s_tready, "pipeline stalled with empty output")
    `RHS_ASSERT(a_hue_range, aclk, aresetn, v5_reg |-> (hue_reg < 9'd360), "hue out of range")
    `RHS_ASSERT(a_gray_hue, aclk, aresetn, (v5_reg && sat_reg == 8'd0) |-> (hue_reg == 9'd300 && skin_reg == 9'h1C4), "gray pixel hue mismatch")
    `RHS_ASSERT(a_skin_wrap, aclk, aresetn, (v5_reg && hue_reg > 9'd180) |-> (skin_reg == 9'(hue_reg + 9'd152)), "skin hue inconsistent with hue")
    `RHS_ASSERT_ALWAYS(a_reset_clears, aclk, !$past(aresetn) |-> !m_tvalid, "valid set after reset")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hue and saturation core testbench
// Streams 8-bit RGB pixels into the core and checks each hue, signed skin hue
// and saturation result against a stored or predicted value. A directed table
// covers the primaries, the tied maxima, gray and black pixels and the
// truncation edge. A random phase follows with gaps on both stream sides.
// ----------------------------------------------------------------------------

module testbench;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [8:0]        hue;
        logic signed [8:0] skin;
        logic [7:0]        sat;
    } hsv_t;

    typedef struct packed {
        pixel_t pix;
        hsv_t   hsv;
    } hsv_entry_t;

    typedef struct {
        logic [7:0] r, g, b;
        bit         known;
        int         hue, skin, sat;
    } directed_row_t;

    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM   = 700;

    // Rows with known set carry their expected result; the rest are predicted.
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, 300, -60,  255},
        '{8'd255, 8'd255, 8'd255, 1'b1, 300, -60,  0},
        '{8'd128, 8'd128, 8'd128, 1'b1, 300, -60,  0},
        '{8'd255, 8'd0,   8'd0,   1'b1, 0,   0,    255},
        '{8'd0,   8'd255, 8'd0,   1'b1, 120, 120,  255},
        '{8'd0,   8'd0,   8'd255, 1'b1, 240, -120, 255},
        '{8'd255, 8'd255, 8'd0,   1'b1, 60,  60,   255},
        '{8'd0,   8'd255, 8'd255, 1'b1, 180, 180,  255},
        '{8'd255, 8'd0,   8'd255, 1'b1, 300, -60,  255},
        '{8'd1,   8'd0,   8'd0,   1'b0, 0,   0,    0},
        '{8'd62,  8'd1,   8'd61,  1'b0, 0,   0,    0},
        '{8'd255, 8'd0,   8'd128, 1'b0, 0,   0,    0},
        '{8'd255, 8'd128, 8'd0,   1'b0, 0,   0,    0},
        '{8'd128, 8'd255, 8'd0,   1'b0, 0,   0,    0},
        '{8'd0,   8'd255, 8'd128, 1'b0, 0,   0,    0},
        '{8'd0,   8'd128, 8'd255, 1'b0, 0,   0,    0},
        '{8'd128, 8'd0,   8'd255, 1'b0, 0,   0,    0},
        '{8'd255, 8'd254, 8'd253, 1'b0, 0,   0,    0},
        '{8'd1,   8'd1,   8'd0,   1'b0, 0,   0,    0},
        '{8'd0,   8'd1,   8'd1,   1'b0, 0,   0,    0},
        '{8'd1,   8'd0,   8'd1,   1'b0, 0,   0,    0},
        '{8'd170, 8'd85,  8'd85,  1'b0, 0,   0,    0},
        '{8'd85,  8'd170, 8'd170, 1'b0, 0,   0,    0},
        '{8'd254, 8'd255, 8'd254, 1'b0, 0,   0,    0}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // red_in[7:0], green_in[15:8], blue_in[23:16]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // hue_deg[8:0], skin_hue_deg[17:9], saturation[25:18]

    hsv_entry_t hsv_queue [$];
    hsv_entry_t next_entry;
    hsv_entry_t oldest;
    hsv_t       got;
    bit         no_idle;
    int         error_count;
    int         results_checked;
    int         tie_or_gray_sent;

    rgb_to_hue_saturation_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic hsv_t hue_sat_of(pixel_t p);
        int   r, g, b, mx, mn, d, rs, gs, bs, h;
        hsv_t res;
        r  = p.r;
        g  = p.g;
        b  = p.b;
        mx = (r > g) ? r : g;
        mx = (b > mx) ? b : mx;
        mn = (r < g) ? r : g;
        mn = (b < mn) ? b : mn;
        d  = mx - mn;
        if (d == 0) begin
            h = -60;
        end else begin
            rs = (r * 60) / d;
            gs = (g * 60) / d;
            bs = (b * 60) / d;
            if (r > g && r > b) begin
                h = gs - bs;
            end else if (g > r && g > b) begin
                h = 120 + bs - rs;
            end else if (b > r && b > g) begin
                h = 240 + rs - gs;
            end else if (r == g && r == mx) begin
                h = 60;
            end else if (g == b && g == mx) begin
                h = 180;
            end else begin
                h = 300;
            end
        end
        res.hue  = 9'((h < 0) ? h + 360 : h);
        res.skin = 9'((h > 180) ? h - 360 : h);
        res.sat  = 8'((mx > 0) ? (d * 255) / mx : 255);
        return res;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] edge_value();
        case ($urandom_range(0, 3))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic pixel_t random_pixel(output int mode);
        pixel_t p;
        int     top, low, mn, d, turns;
        mode = $urandom_range(0, 9);
        p.r  = 8'($urandom_range(0, 255));
        p.g  = 8'($urandom_range(0, 255));
        p.b  = 8'($urandom_range(0, 255));
        case (mode)
            5: begin
                top = $urandom_range(0, 255);
                low = $urandom_range(0, top);
                case ($urandom_range(0, 2))
                    0: p = {top[7:0], top[7:0], low[7:0]};
                    1: p = {low[7:0], top[7:0], top[7:0]};
                    default: p = {top[7:0], low[7:0], top[7:0]};
                endcase
            end
            6: begin
                p.g = p.r;
                p.b = p.r;
            end
            7: begin
                mn  = $urandom_range(0, 252);
                p.r = 8'(mn + $urandom_range(0, 3));
                p.g = 8'(mn + $urandom_range(0, 3));
                p.b = 8'(mn + $urandom_range(0, 3));
            end
            8: begin
                p.r = edge_value();
                p.g = edge_value();
                p.b = edge_value();
            end
            9: begin
                d     = $urandom_range(55, 70);
                mn    = $urandom_range(0, 255 - d);
                p.r   = 8'(mn + d);
                p.g   = 8'(mn);
                p.b   = 8'(mn + $urandom_range(0, d));
                turns = $urandom_range(0, 2);
                repeat (turns) p = {p.g, p.b, p.r};
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_pixel(pixel_t p, hsv_t want);
        int gap;
        gap = no_idle ? 0 : gap_len();
        @(negedge aclk);
        repeat (gap) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        next_entry = '{pix: p, hsv: want};
        s_tdata    = {p.b, p.g, p.r};
        s_tvalid   = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (hsv_queue.size() != 0) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                hsv_queue.push_back(next_entry);
            end
            if (m_tvalid && m_tready) begin
                got.hue  = m_tdata[8:0];
                got.skin = m_tdata[17:9];
                got.sat  = m_tdata[25:18];
                if (hsv_queue.size() == 0) begin
                    report_error($sformatf("result transaction with no pixel outstanding (%h)",
                                           m_tdata));
                end else begin
                    oldest = hsv_queue.pop_front();
                    results_checked++;
                    if (got.hue !== oldest.hsv.hue) begin
                        report_error($sformatf("rgb %0d,%0d,%0d hue_deg %0d, expected %0d",
                                               oldest.pix.r, oldest.pix.g, oldest.pix.b,
                                               got.hue, oldest.hsv.hue));
                    end
                    if (got.skin !== oldest.hsv.skin) begin
                        report_error($sformatf("rgb %0d,%0d,%0d skin_hue_deg %0d, expected %0d",
                                               oldest.pix.r, oldest.pix.g, oldest.pix.b,
                                               got.skin, oldest.hsv.skin));
                    end
                    if (got.sat !== oldest.hsv.sat) begin
                        report_error($sformatf("rgb %0d,%0d,%0d saturation %0d, expected %0d",
                                               oldest.pix.r, oldest.pix.g, oldest.pix.b,
                                               got.sat, oldest.hsv.sat));
                    end
                end
            end
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0 && !no_idle) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready   = 1'b1;
                stall_left = 0;
                if (!no_idle && $urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still outstanding.", hsv_queue.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        pixel_t p;
        hsv_t   want;
        int     mode;
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        no_idle          = 1'b0;
        error_count      = 0;
        results_checked  = 0;
        tie_or_gray_sent = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i]) begin
            p = {directed_rows[i].r, directed_rows[i].g, directed_rows[i].b};
            if (directed_rows[i].known) begin
                want.hue  = 9'(directed_rows[i].hue);
                want.skin = 9'(directed_rows[i].skin);
                want.sat  = 8'(directed_rows[i].sat);
            end else begin
                want = hue_sat_of(p);
            end
            send_pixel(p, want);
        end
        wait_for_results();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 100 == 0) begin
                no_idle = (i == 300) || ($urandom_range(0, 4) == 0);
            end
            if (i == 350) begin
                wait_for_results();
            end
            p = random_pixel(mode);
            if (mode == 5 || mode == 6) begin
                tie_or_gray_sent++;
            end
            send_pixel(p, hue_sat_of(p));
        end
        wait_for_results();
        repeat (20) @(posedge aclk);

        $display("Sent %0d table pixels and %0d random pixels, %0d of them gray or tied.",
                 NUM_DIRECTED, NUM_RANDOM, tie_or_gray_sent);
        $display("Checked %0d results with %0d mismatches.", results_checked, error_count);
        if (error_count == 0 && hsv_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+design
design/rhs_pkg.sv
design/rhs_recip_div.sv
design/rgb_to_hue_saturation_core.sv
tb/sv/testbench.sv
